### src/ahe_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive Huffman encoder package
// Shared widths, default sizes and the sequencer state codes.
// ----------------------------------------------------------------------------
package ahe_pkg;

    // Default sizes of the node table, the symbol slots and the code cap.
    localparam int NODE_COUNT_DEF    = 515;
    localparam int SYMBOL_SLOTS_DEF  = 258;
    localparam int MAX_CODE_BITS_DEF = 32;

    // Fixed field widths.
    localparam int WEIGHT_W  = 16;
    localparam int LIMIT_W   = 16;
    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int LITERAL_W = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd32768;

    // Sequencer states, one-hot.
    localparam int ST_W = 47;

    typedef enum logic [ST_W-1:0] {
        S_INIT0  = (47'd1 << 0),
        S_INIT1  = (47'd1 << 1),
        S_INIT2  = (47'd1 << 2),
        S_IDLE   = (47'd1 << 3),
        S_PLEAF  = (47'd1 << 4),
        S_PSTEP  = (47'd1 << 5),
        S_PRD    = (47'd1 << 6),
        S_EMIT1  = (47'd1 << 7),
        S_EMIT2  = (47'd1 << 8),
        S_ADD0   = (47'd1 << 9),
        S_ADD1   = (47'd1 << 10),
        S_ADD2   = (47'd1 << 11),
        S_ADD3   = (47'd1 << 12),
        S_RCHK   = (47'd1 << 13),
        S_RCHK1  = (47'd1 << 14),
        S_RSTART = (47'd1 << 15),
        S_RLEAF  = (47'd1 << 16),
        S_RINC   = (47'd1 << 17),
        S_RINC1  = (47'd1 << 18),
        S_RSCAN  = (47'd1 << 19),
        S_RSCAN1 = (47'd1 << 20),
        S_RDEC   = (47'd1 << 21),
        S_X0     = (47'd1 << 22),
        S_X1     = (47'd1 << 23),
        S_X2     = (47'd1 << 24),
        S_X3     = (47'd1 << 25),
        S_X4     = (47'd1 << 26),
        S_X5     = (47'd1 << 27),
        S_X6     = (47'd1 << 28),
        S_X7     = (47'd1 << 29),
        S_X8     = (47'd1 << 30),
        S_RNEXT  = (47'd1 << 31),
        S_RPAR   = (47'd1 << 32),
        S_B1     = (47'd1 << 33),
        S_B1R    = (47'd1 << 34),
        S_B2     = (47'd1 << 35),
        S_B2A    = (47'd1 << 36),
        S_B2B    = (47'd1 << 37),
        S_B2K    = (47'd1 << 38),
        S_B2K1   = (47'd1 << 39),
        S_B2KD   = (47'd1 << 40),
        S_B2M    = (47'd1 << 41),
        S_B2M1   = (47'd1 << 42),
        S_B2W    = (47'd1 << 43),
        S_B3     = (47'd1 << 44),
        S_B3R    = (47'd1 << 45),
        S_B3P    = (47'd1 << 46)
    } state_t;

endpackage

### src/adaptive_huffman_encoder.sv
// ----------------------------------------------------------------------------
// Adaptive Huffman encoder
// Codes bytes with an adaptive, sibling-ordered Huffman node table kept in RAM.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// the item's results are out and the tree is updated. Each result appears for
// one cycle with result_valid high and must be captured then. An unseen byte
// gives two results (escape path, then the 8-bit literal). Timing is set by
// the single read port of the node memory: coding reads the path one tree
// level at a time and then sends the literal, if any; a leaf is then added
// if the table has room; the update raises each level with a sibling scan and
// a swap where needed. A rebuild, when the root weight reaches limit_reg (set
// from cfg_data), halves and packs each leaf in use, then forms, places by
// scan and shift, and links each internal node. After reset and after end of
// stream the tree is reloaded.
module adaptive_huffman_encoder
    import ahe_pkg::*;
#(
    parameter int NODE_COUNT    = NODE_COUNT_DEF,
    parameter int SYMBOL_SLOTS  = SYMBOL_SLOTS_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 action,
    input  logic [7:0]           symbol,
    input  logic                 cfg_write,
    input  logic [LIMIT_W-1:0]   cfg_data,
    output logic                 result_valid,
    output logic [CODE_W-1:0]    code_bits,
    output logic [LEN_W-1:0]     code_length,
    output logic                 last
);

    localparam int NODE_AW  = $clog2(NODE_COUNT);
    localparam int SLOT_AW  = $clog2(SYMBOL_SLOTS);
    localparam int CHILD_W  = (NODE_AW > SLOT_AW) ? NODE_AW : SLOT_AW;
    localparam int IDX_W    = NODE_AW + 2;
    localparam int NODE_W   = WEIGHT_W + CHILD_W + 1 + NODE_AW;
    localparam int LEAF_BIT = NODE_AW;
    localparam int CHILD_LO = NODE_AW + 1;
    localparam int CODE_CAP = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
    localparam int SYM_END  = SYMBOL_SLOTS - 2;
    localparam int SYM_ESC  = SYMBOL_SLOTS - 1;

    localparam logic [NODE_W-1:0] MASK_ALL = '1;
    localparam logic [NODE_W-1:0] MASK_PAR = {{(NODE_W-NODE_AW){1'b0}}, {NODE_AW{1'b1}}};
    localparam logic [NODE_W-1:0] MASK_WGT = {{WEIGHT_W{1'b1}}, {(NODE_W-WEIGHT_W){1'b0}}};
    localparam logic [NODE_W-1:0] MASK_CHL =
        {{WEIGHT_W{1'b0}}, {(CHILD_W+1){1'b1}}, {NODE_AW{1'b0}}};

    // State registers.
    state_t                    state_reg, state_next;
    logic [NODE_AW:0]          nf_reg, nf_next;
    logic [LIMIT_W-1:0]        limit_reg;
    logic [SYMBOL_SLOTS-1:0]   valid_reg, valid_next;
    logic [CODE_CAP-1:0]       code_reg, code_next;
    logic [LEN_W-1:0]          dcnt_reg, dcnt_next;
    logic [NODE_AW-1:0]        n_reg, n_next;
    logic [NODE_AW-1:0]        cur_reg, cur_next;
    logic [NODE_AW-1:0]        up_reg, up_next;
    logic [WEIGHT_W-1:0]       wc_reg, wc_next;
    logic [WEIGHT_W-1:0]       wa_reg, wa_next;
    logic signed [IDX_W-1:0]   i_reg, i_next;
    logic signed [IDX_W-1:0]   j_reg, j_next;
    logic signed [IDX_W-1:0]   k_reg, k_next;
    logic signed [IDX_W-1:0]   m_reg, m_next;
    logic [WEIGHT_W-1:0]       aw_reg, aw_next, bw_reg, bw_next;
    logic [CHILD_W-1:0]        ac_reg, ac_next, bc_reg, bc_next;
    logic                      al_reg, al_next, bl_reg, bl_next;
    logic [NODE_AW-1:0]        ap_reg, ap_next, bp_reg, bp_next;
    logic [7:0]                sym_reg, sym_next;
    logic                      end_reg, end_next;
    logic                      lit_reg, lit_next;
    logic                      add_reg, add_next;
    logic                      ok_reg, ok_next;
    logic                      ov_reg, ov_next;
    logic [CODE_W-1:0]         ob_reg, ob_next;
    logic [LEN_W-1:0]          ol_reg, ol_next;
    logic                      olast_reg, olast_next;

    // Memory ports.
    logic                      node_we;
    logic [NODE_AW-1:0]        node_waddr, node_raddr;
    logic [NODE_W-1:0]         node_wmask, node_wdata, node_rdata;
    logic                      leaf_we;
    logic [SLOT_AW-1:0]        leaf_waddr, leaf_raddr;
    logic [NODE_AW-1:0]        leaf_wdata, leaf_rdata;

    // Read data fields.
    logic [WEIGHT_W-1:0]       rd_w;
    logic [CHILD_W-1:0]        rd_c;
    logic                      rd_l;
    logic [NODE_AW-1:0]        rd_p;
    logic signed [IDX_W-1:0]   top_s;
    logic [SLOT_AW-1:0]        sym_idx, in_idx;
    logic                      in_ok, in_known;
    logic [CHILD_W:0]          ac1, bc1;
    logic [WEIGHT_W:0]         half_sum;

    assign rd_w = node_rdata[NODE_W-1 -: WEIGHT_W];
    assign rd_c = node_rdata[CHILD_LO +: CHILD_W];
    assign rd_l = node_rdata[LEAF_BIT];
    assign rd_p = node_rdata[NODE_AW-1:0];
    assign top_s = $signed({1'b0, nf_reg} - {{(IDX_W-1){1'b0}}, 1'b1});
    assign sym_idx = SLOT_AW'(sym_reg);
    assign in_idx = SLOT_AW'(symbol);
    assign in_ok = (int'(symbol) < SYM_END);
    assign in_known = in_ok && valid_reg[in_idx];
    assign ac1 = {1'b0, ac_reg} + {{CHILD_W{1'b0}}, 1'b1};
    assign bc1 = {1'b0, bc_reg} + {{CHILD_W{1'b0}}, 1'b1};
    assign half_sum = ({1'b0, rd_w} + {{WEIGHT_W{1'b0}}, 1'b1}) >> 1;

    // Node table: weight, child, leaf flag and parent of each node.
    ahe_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wmask (node_wmask),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // Leaf node of each symbol slot.
    ahe_ram #(.WIDTH(NODE_AW), .DEPTH(SYMBOL_SLOTS)) u_leaf_ram (
        .clk   (clk),
        .we    (leaf_we),
        .waddr (leaf_waddr),
        .wmask ({NODE_AW{1'b1}}),
        .wdata (leaf_wdata),
        .raddr (leaf_raddr),
        .rdata (leaf_rdata)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        nf_next    = nf_reg;
        valid_next = valid_reg;
        code_next  = code_reg;
        dcnt_next  = dcnt_reg;
        n_next     = n_reg;
        cur_next   = cur_reg;
        up_next    = up_reg;
        wc_next    = wc_reg;
        wa_next    = wa_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        m_next     = m_reg;
        aw_next    = aw_reg;
        ac_next    = ac_reg;
        al_next    = al_reg;
        ap_next    = ap_reg;
        bw_next    = bw_reg;
        bc_next    = bc_reg;
        bl_next    = bl_reg;
        bp_next    = bp_reg;
        sym_next   = sym_reg;
        end_next   = end_reg;
        lit_next   = lit_reg;
        add_next   = add_reg;
        ok_next    = ok_reg;
        ov_next    = 1'b0;
        ob_next    = ob_reg;
        ol_next    = ol_reg;
        olast_next = olast_reg;
        node_we    = 1'b0;
        node_waddr = '0;
        node_wmask = '0;
        node_wdata = '0;
        node_raddr = '0;
        leaf_we    = 1'b0;
        leaf_waddr = '0;
        leaf_wdata = '0;
        leaf_raddr = '0;

        case (state_reg)
            // Load the three-node starting tree.
            S_INIT0:
            begin
                valid_next = '0;
                nf_next    = (NODE_AW+1)'(3);
                node_we    = 1'b1;
                node_waddr = '0;
                node_wmask = MASK_ALL;
                node_wdata = {WEIGHT_W'(2), CHILD_W'(1), 1'b0, {NODE_AW{1'b0}}};
                leaf_we    = 1'b1;
                leaf_waddr = SLOT_AW'(SYM_END);
                leaf_wdata = NODE_AW'(1);
                state_next = S_INIT1;
            end
            S_INIT1:
            begin
                node_we    = 1'b1;
                node_waddr = NODE_AW'(1);
                node_wmask = MASK_ALL;
                node_wdata = {WEIGHT_W'(1), CHILD_W'(SYM_END), 1'b1, {NODE_AW{1'b0}}};
                leaf_we    = 1'b1;
                leaf_waddr = SLOT_AW'(SYM_ESC);
                leaf_wdata = NODE_AW'(2);
                state_next = S_INIT2;
            end
            S_INIT2:
            begin
                node_we    = 1'b1;
                node_waddr = NODE_AW'(2);
                node_wmask = MASK_ALL;
                node_wdata = {WEIGHT_W'(1), CHILD_W'(SYM_ESC), 1'b1, {NODE_AW{1'b0}}};
                state_next = S_IDLE;
            end

            // Take an item and look up the leaf whose path is sent.
            S_IDLE:
            begin
                if (start)
                begin
                    sym_next  = symbol;
                    end_next  = action;
                    ok_next   = in_ok;
                    lit_next  = !action && !in_known;
                    add_next  = !action && !in_known && in_ok &&
                                (int'(nf_reg) + 2 <= NODE_COUNT);
                    code_next = '0;
                    dcnt_next = '0;
                    if (action)
                    begin
                        leaf_raddr = SLOT_AW'(SYM_END);
                    end
                    else if (in_known)
                    begin
                        leaf_raddr = in_idx;
                    end
                    else
                    begin
                        leaf_raddr = SLOT_AW'(SYM_ESC);
                    end
                    state_next = S_PLEAF;
                end
            end
            S_PLEAF:
            begin
                n_next     = leaf_rdata;
                state_next = S_PSTEP;
            end

            // Walk to the root, collecting one code bit per level.
            S_PSTEP:
            begin
                if (n_reg == '0)
                begin
                    ob_next    = CODE_W'(code_reg >> (LEN_W'(CODE_CAP) - dcnt_reg));
                    ol_next    = dcnt_reg;
                    olast_next = !lit_reg;
                    ov_next    = 1'b1;
                    state_next = S_EMIT1;
                end
                else
                begin
                    code_next = {~n_reg[0], code_reg[CODE_CAP-1:1]};
                    if (dcnt_reg != LEN_W'(CODE_CAP))
                    begin
                        dcnt_next = dcnt_reg + LEN_W'(1);
                    end
                    node_raddr = n_reg;
                    state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                n_next     = rd_p;
                state_next = S_PSTEP;
            end

            // Path result is on the ports; follow with the literal if needed.
            S_EMIT1:
            begin
                if (lit_reg)
                begin
                    ob_next    = CODE_W'(sym_reg);
                    ol_next    = LEN_W'(LITERAL_W);
                    olast_next = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_EMIT2;
                end
                else if (end_reg)
                begin
                    state_next = S_INIT0;
                end
                else
                begin
                    state_next = S_RCHK;
                end
            end
            S_EMIT2:
            begin
                state_next = add_reg ? S_ADD0 : S_RCHK;
            end

            // Split the lightest node into its old content and a new zero leaf.
            S_ADD0:
            begin
                node_raddr = NODE_AW'(nf_reg - 1'b1);
                state_next = S_ADD1;
            end
            S_ADD1:
            begin
                ac_next    = rd_c;
                al_next    = rd_l;
                node_we    = 1'b1;
                node_waddr = NODE_AW'(nf_reg);
                node_wmask = MASK_ALL;
                node_wdata = {rd_w, rd_c, rd_l, NODE_AW'(nf_reg - 1'b1)};
                state_next = S_ADD2;
            end
            S_ADD2:
            begin
                node_we    = 1'b1;
                node_waddr = NODE_AW'(nf_reg - 1'b1);
                node_wmask = MASK_CHL;
                node_wdata = {{WEIGHT_W{1'b0}}, CHILD_W'(nf_reg), 1'b0, {NODE_AW{1'b0}}};
                if (al_reg && (int'(ac_reg) < SYMBOL_SLOTS))
                begin
                    leaf_we    = 1'b1;
                    leaf_waddr = ac_reg[SLOT_AW-1:0];
                    leaf_wdata = NODE_AW'(nf_reg);
                end
                state_next = S_ADD3;
            end
            S_ADD3:
            begin
                node_we    = 1'b1;
                node_waddr = NODE_AW'(nf_reg + 1'b1);
                node_wmask = MASK_ALL;
                node_wdata = {{WEIGHT_W{1'b0}}, CHILD_W'(sym_reg), 1'b1,
                              NODE_AW'(nf_reg - 1'b1)};
                leaf_we    = 1'b1;
                leaf_waddr = sym_idx;
                leaf_wdata = NODE_AW'(nf_reg + 1'b1);
                nf_next    = nf_reg + (NODE_AW+1)'(2);
                state_next = S_RCHK;
            end

            // Rebuild check on the root weight.
            S_RCHK:
            begin
                node_raddr = '0;
                state_next = S_RCHK1;
            end
            S_RCHK1:
            begin
                if (rd_w >= limit_reg)
                begin
                    i_next     = top_s;
                    j_next     = top_s;
                    state_next = S_B1;
                end
                else
                begin
                    state_next = S_RSTART;
                end
            end

            // Raise weights from the symbol's leaf to the root.
            S_RSTART:
            begin
                if (ok_reg && valid_reg[sym_idx])
                begin
                    leaf_raddr = sym_idx;
                    state_next = S_RLEAF;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RLEAF:
            begin
                cur_next   = leaf_rdata;
                state_next = S_RINC;
            end
            S_RINC:
            begin
                node_raddr = cur_reg;
                state_next = S_RINC1;
            end
            S_RINC1:
            begin
                wc_next    = rd_w + WEIGHT_W'(1);
                node_we    = 1'b1;
                node_waddr = cur_reg;
                node_wmask = MASK_WGT;
                node_wdata = {rd_w + WEIGHT_W'(1), {(NODE_W-WEIGHT_W){1'b0}}};
                up_next    = cur_reg;
                state_next = S_RSCAN;
            end
            S_RSCAN:
            begin
                if (up_reg == '0)
                begin
                    state_next = S_RDEC;
                end
                else
                begin
                    node_raddr = up_reg - NODE_AW'(1);
                    state_next = S_RSCAN1;
                end
            end
            S_RSCAN1:
            begin
                if (rd_w < wc_reg)
                begin
                    up_next    = up_reg - NODE_AW'(1);
                    state_next = S_RSCAN;
                end
                else
                begin
                    state_next = S_RDEC;
                end
            end
            S_RDEC:
            begin
                state_next = (up_reg != cur_reg) ? S_X0 : S_RNEXT;
            end

            // Swap node cur with node up, keeping parents by position.
            S_X0:
            begin
                node_raddr = cur_reg;
                state_next = S_X1;
            end
            S_X1:
            begin
                aw_next    = rd_w;
                ac_next    = rd_c;
                al_next    = rd_l;
                ap_next    = rd_p;
                node_raddr = up_reg;
                state_next = S_X2;
            end
            S_X2:
            begin
                bw_next    = rd_w;
                bc_next    = rd_c;
                bl_next    = rd_l;
                bp_next    = rd_p;
                state_next = S_X3;
            end
            S_X3:
            begin
                if (al_reg)
                begin
                    if (int'(ac_reg) < SYMBOL_SLOTS)
                    begin
                        leaf_we    = 1'b1;
                        leaf_waddr = ac_reg[SLOT_AW-1:0];
                        leaf_wdata = up_reg;
                    end
                end
                else if (int'(ac_reg) < NODE_COUNT)
                begin
                    node_we    = 1'b1;
                    node_waddr = ac_reg[NODE_AW-1:0];
                    node_wmask = MASK_PAR;
                    node_wdata = {{(NODE_W-NODE_AW){1'b0}}, up_reg};
                end
                state_next = S_X4;
            end
            S_X4:
            begin
                if (!al_reg && (int'(ac1) < NODE_COUNT))
                begin
                    node_we    = 1'b1;
                    node_waddr = ac1[NODE_AW-1:0];
                    node_wmask = MASK_PAR;
                    node_wdata = {{(NODE_W-NODE_AW){1'b0}}, up_reg};
                end
                state_next = S_X5;
            end
            S_X5:
            begin
                if (bl_reg)
                begin
                    if (int'(bc_reg) < SYMBOL_SLOTS)
                    begin
                        leaf_we    = 1'b1;
                        leaf_waddr = bc_reg[SLOT_AW-1:0];
                        leaf_wdata = cur_reg;
                    end
                end
                else if (int'(bc_reg) < NODE_COUNT)
                begin
                    node_we    = 1'b1;
                    node_waddr = bc_reg[NODE_AW-1:0];
                    node_wmask = MASK_PAR;
                    node_wdata = {{(NODE_W-NODE_AW){1'b0}}, cur_reg};
                end
                state_next = S_X6;
            end
            S_X6:
            begin
                if (!bl_reg && (int'(bc1) < NODE_COUNT))
                begin
                    node_we    = 1'b1;
                    node_waddr = bc1[NODE_AW-1:0];
                    node_wmask = MASK_PAR;
                    node_wdata = {{(NODE_W-NODE_AW){1'b0}}, cur_reg};
                end
                state_next = S_X7;
            end
            S_X7:
            begin
                node_we    = 1'b1;
                node_waddr = cur_reg;
                node_wmask = MASK_ALL;
                node_wdata = {bw_reg, bc_reg, bl_reg, ap_reg};
                state_next = S_X8;
            end
            S_X8:
            begin
                node_we    = 1'b1;
                node_waddr = up_reg;
                node_wmask = MASK_ALL;
                node_wdata = {aw_reg, ac_reg, al_reg, bp_reg};
                cur_next   = up_reg;
                state_next = S_RNEXT;
            end

            // Step to the parent, or finish at the root.
            S_RNEXT:
            begin
                if (cur_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    node_raddr = cur_reg;
                    state_next = S_RPAR;
                end
            end
            S_RPAR:
            begin
                cur_next   = rd_p;
                state_next = S_RINC;
            end

            // Rebuild, first pass: pack halved leaves at the top of the table.
            S_B1:
            begin
                if (i_reg[IDX_W-1])
                begin
                    i_next     = top_s - IDX_W'(1);
                    state_next = S_B2;
                end
                else
                begin
                    node_raddr = i_reg[NODE_AW-1:0];
                    state_next = S_B1R;
                end
            end
            S_B1R:
            begin
                if (rd_l)
                begin
                    node_we    = 1'b1;
                    node_waddr = j_reg[NODE_AW-1:0];
                    node_wmask = MASK_ALL;
                    node_wdata = {half_sum[WEIGHT_W-1:0], rd_c, 1'b1, rd_p};
                    j_next     = j_reg - IDX_W'(1);
                end
                i_next     = i_reg - IDX_W'(1);
                state_next = S_B1;
            end

            // Second pass: form internal nodes and insert them in order.
            S_B2:
            begin
                if (j_reg[IDX_W-1] || i_reg[IDX_W-1])
                begin
                    i_next     = top_s;
                    state_next = S_B3;
                end
                else
                begin
                    node_raddr = i_reg[NODE_AW-1:0];
                    state_next = S_B2A;
                end
            end
            S_B2A:
            begin
                wa_next    = rd_w;
                node_raddr = NODE_AW'(i_reg + IDX_W'(1));
                state_next = S_B2B;
            end
            S_B2B:
            begin
                wa_next    = wa_reg + rd_w;
                k_next     = j_reg + IDX_W'(1);
                state_next = S_B2K;
            end
            S_B2K:
            begin
                if (k_reg > top_s)
                begin
                    state_next = S_B2KD;
                end
                else
                begin
                    node_raddr = k_reg[NODE_AW-1:0];
                    state_next = S_B2K1;
                end
            end
            S_B2K1:
            begin
                if (wa_reg < rd_w)
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = S_B2K;
                end
                else
                begin
                    state_next = S_B2KD;
                end
            end
            S_B2KD:
            begin
                k_next     = k_reg - IDX_W'(1);
                m_next     = j_reg;
                state_next = S_B2M;
            end
            S_B2M:
            begin
                if (m_reg < k_reg)
                begin
                    node_raddr = NODE_AW'(m_reg + IDX_W'(1));
                    state_next = S_B2M1;
                end
                else
                begin
                    state_next = S_B2W;
                end
            end
            S_B2M1:
            begin
                node_we    = 1'b1;
                node_waddr = m_reg[NODE_AW-1:0];
                node_wmask = MASK_ALL;
                node_wdata = node_rdata;
                m_next     = m_reg + IDX_W'(1);
                state_next = S_B2M;
            end
            S_B2W:
            begin
                node_we    = 1'b1;
                node_waddr = k_reg[NODE_AW-1:0];
                node_wmask = ~MASK_PAR;
                node_wdata = {wa_reg, CHILD_W'(i_reg), 1'b0, {NODE_AW{1'b0}}};
                i_next     = i_reg - IDX_W'(2);
                j_next     = j_reg - IDX_W'(1);
                state_next = S_B2;
            end

            // Third pass: point children and leaf slots back at each node.
            S_B3:
            begin
                if (i_reg[IDX_W-1])
                begin
                    state_next = S_RSTART;
                end
                else
                begin
                    node_raddr = i_reg[NODE_AW-1:0];
                    state_next = S_B3R;
                end
            end
            S_B3R:
            begin
                ac_next = rd_c;
                al_next = rd_l;
                if (rd_l)
                begin
                    if (int'(rd_c) < SYMBOL_SLOTS)
                    begin
                        leaf_we    = 1'b1;
                        leaf_waddr = rd_c[SLOT_AW-1:0];
                        leaf_wdata = i_reg[NODE_AW-1:0];
                    end
                end
                else if (int'(rd_c) < NODE_COUNT)
                begin
                    node_we    = 1'b1;
                    node_waddr = rd_c[NODE_AW-1:0];
                    node_wmask = MASK_PAR;
                    node_wdata = {{(NODE_W-NODE_AW){1'b0}}, i_reg[NODE_AW-1:0]};
                end
                state_next = S_B3P;
            end
            S_B3P:
            begin
                if (!al_reg && (int'(ac1) < NODE_COUNT))
                begin
                    node_we    = 1'b1;
                    node_waddr = ac1[NODE_AW-1:0];
                    node_wmask = MASK_PAR;
                    node_wdata = {{(NODE_W-NODE_AW){1'b0}}, i_reg[NODE_AW-1:0]};
                end
                i_next     = i_reg - IDX_W'(1);
                state_next = S_B3;
            end

            default:
            begin
                state_next = S_INIT0;
            end
        endcase

        // Every leaf slot write makes the slot present.
        if (leaf_we)
        begin
            valid_next[leaf_waddr] = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT0;
            nf_reg    <= '0;
            valid_reg <= '0;
            limit_reg <= LIMIT_RESET;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nf_reg    <= nf_next;
            valid_reg <= valid_next;
            ov_reg    <= ov_next;
            if (cfg_write)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        dcnt_reg  <= dcnt_next;
        n_reg     <= n_next;
        cur_reg   <= cur_next;
        up_reg    <= up_next;
        wc_reg    <= wc_next;
        wa_reg    <= wa_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        m_reg     <= m_next;
        aw_reg    <= aw_next;
        ac_reg    <= ac_next;
        al_reg    <= al_next;
        ap_reg    <= ap_next;
        bw_reg    <= bw_next;
        bc_reg    <= bc_next;
        bl_reg    <= bl_next;
        bp_reg    <= bp_next;
        sym_reg   <= sym_next;
        end_reg   <= end_next;
        lit_reg   <= lit_next;
        add_reg   <= add_next;
        ok_reg    <= ok_next;
        ob_reg    <= ob_next;
        ol_reg    <= ol_next;
        olast_reg <= olast_next;
    end

    // Outputs.
    assign busy         = (state_reg != S_IDLE);
    assign result_valid = ov_reg;
    assign code_bits    = ob_reg;
    assign code_length  = ol_reg;
    assign last         = olast_reg;

    // Checks.
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe outside of an item");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    a_literal_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> (result_valid && last &&
                                     code_length == LEN_W'(LITERAL_W)))
        else $error("escape result not followed by literal");

    a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_INIT0) |-> (int'(nf_reg) <= NODE_COUNT))
        else $error("node table overrun");

endmodule

### src/ahe_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port with a bit mask, one read port with registered read data.
// ----------------------------------------------------------------------------
module ahe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wmask,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Masked write.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int b = 0; b < WIDTH; b++)
            begin
                if (wmask[b])
                begin
                    mem[waddr][b] <= wdata[b];
                end
            end
        end
    end

    // Registered read.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### tb/adaptive_huffman_encoder_test.sv
// ----------------------------------------------------------------------------
// Adaptive Huffman encoder testbench
// Drives byte and end-of-stream items into the encoder, predicts every escape,
// literal and path code with a local copy of the adaptive node table, and
// compares each result field by field. Runs through several rescale limits,
// including the smallest and the reset value, with random sender gaps.
// ----------------------------------------------------------------------------
module adaptive_huffman_encoder_test;
    import ahe_pkg::*;

    localparam int NODES   = NODE_COUNT_DEF;
    localparam int SLOTS   = SYMBOL_SLOTS_DEF;
    localparam int CAP     = (MAX_CODE_BITS_DEF < 32) ? MAX_CODE_BITS_DEF : 32;
    localparam int END_SYM = SLOTS - 2;
    localparam int ESC_SYM = SLOTS - 1;
    localparam logic ACT_CODE = 1'b0;
    localparam logic ACT_END  = 1'b1;
    localparam int CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  length;
        logic              fin;
    } code_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic action = 1'b0;
    logic [7:0] symbol = 8'd0;
    logic cfg_write = 1'b0;
    logic [LIMIT_W-1:0] cfg_data = '0;
    logic busy;
    logic result_valid;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0] code_length;
    logic last;

    // Local copy of the node table and coder state.
    logic [WEIGHT_W-1:0] weight_m[NODES];
    int                  child_m[NODES];
    bit                  is_leaf_m[NODES];
    int                  parent_m[NODES];
    int                  leaf_at[SLOTS];
    bit                  leaf_ok[SLOTS];
    int                  free_node;
    logic [LIMIT_W-1:0]  limit_m;

    code_word_t pending_codes[$];
    int errors = 0;
    int cycles = 0;
    int idle_pct = 0;

    adaptive_huffman_encoder u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .symbol(symbol),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .result_valid(result_valid), .code_bits(code_bits),
        .code_length(code_length), .last(last)
    );

    always #1 clk = ~clk;

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- tree model ----------------
    function automatic void tree_clear();
        for (int i = 0; i < NODES; i++)
        begin
            weight_m[i] = '0; child_m[i] = 0; is_leaf_m[i] = 1'b0; parent_m[i] = 0;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            leaf_at[i] = 0; leaf_ok[i] = 1'b0;
        end
        weight_m[0] = 2; child_m[0] = 1;
        weight_m[1] = 1; child_m[1] = END_SYM; is_leaf_m[1] = 1'b1;
        weight_m[2] = 1; child_m[2] = ESC_SYM; is_leaf_m[2] = 1'b1;
        leaf_at[END_SYM] = 1; leaf_ok[END_SYM] = 1'b1;
        leaf_at[ESC_SYM] = 2; leaf_ok[ESC_SYM] = 1'b1;
        free_node = 3;
    endfunction

    function automatic void move_node(int d, int s);
        weight_m[d] = weight_m[s]; child_m[d] = child_m[s];
        is_leaf_m[d] = is_leaf_m[s]; parent_m[d] = parent_m[s];
    endfunction

    function automatic void bind_leaf(int sym, int node);
        if (sym < SLOTS)
        begin
            leaf_at[sym] = node; leaf_ok[sym] = 1'b1;
        end
    endfunction

    function automatic void repoint(int n, int p);
        int ch;
        ch = child_m[n];
        if (is_leaf_m[n])
            bind_leaf(ch, p);
        else
        begin
            if (ch < NODES) parent_m[ch] = p;
            if (ch + 1 < NODES) parent_m[ch + 1] = p;
        end
    endfunction

    function automatic void trade_places(int a, int b);
        int pa, pb, c;
        logic [WEIGHT_W-1:0] w;
        bit l;
        pa = parent_m[a]; pb = parent_m[b];
        w = weight_m[a]; c = child_m[a]; l = is_leaf_m[a];
        repoint(a, b);
        repoint(b, a);
        weight_m[a] = weight_m[b]; child_m[a] = child_m[b]; is_leaf_m[a] = is_leaf_m[b];
        weight_m[b] = w; child_m[b] = c; is_leaf_m[b] = l;
        parent_m[a] = pa; parent_m[b] = pb;
    endfunction

    // Halve the leaf weights and rebuild the internal nodes bottom up.
    function automatic void halve_tree();
        int top, i, j, k;
        logic [WEIGHT_W-1:0] w;
        top = free_node - 1;
        j = top;
        for (i = top; i >= 0; i--)
        begin
            if (is_leaf_m[i])
            begin
                move_node(j, i);
                weight_m[j] = WEIGHT_W'((32'(weight_m[j]) + 1) / 2);
                j--;
            end
        end
        i = top - 1;
        while (j >= 0 && i >= 0)
        begin
            w = weight_m[i] + weight_m[i + 1];
            weight_m[j] = w;
            is_leaf_m[j] = 1'b0;
            k = j + 1;
            while (k <= top && w < weight_m[k]) k++;
            k--;
            for (int m = j; m < k; m++) move_node(m, m + 1);
            weight_m[k] = w; child_m[k] = i; is_leaf_m[k] = 1'b0;
            i -= 2;
            j--;
        end
        for (i = top; i >= 0; i--) repoint(i, i);
    endfunction

    function automatic void split_lightest(int sym);
        int light, fresh, zero;
        light = free_node - 1;
        fresh = free_node;
        zero = free_node + 1;
        free_node += 2;
        move_node(fresh, light);
        parent_m[fresh] = light;
        if (is_leaf_m[fresh]) bind_leaf(child_m[fresh], fresh);
        child_m[light] = fresh;
        is_leaf_m[light] = 1'b0;
        child_m[zero] = sym; is_leaf_m[zero] = 1'b1;
        weight_m[zero] = '0; parent_m[zero] = light;
        bind_leaf(sym, zero);
    endfunction

    function automatic void bump_path(int sym);
        int cur, up;
        if (weight_m[0] >= limit_m) halve_tree();
        if (sym >= SLOTS || !leaf_ok[sym]) return;
        cur = leaf_at[sym];
        for (int steps = 0; steps < NODES && cur < NODES; steps++)
        begin
            weight_m[cur] = weight_m[cur] + 1'b1;
            up = cur;
            while (up > 0 && weight_m[up - 1] < weight_m[cur]) up--;
            if (up != cur)
            begin
                trade_places(cur, up);
                cur = up;
            end
            if (cur == 0) break;
            cur = parent_m[cur];
        end
    endfunction

    function automatic code_word_t path_word(int sym, logic fin);
        code_word_t cw;
        int first, n, d, drop;
        first = (sym < SLOTS && leaf_ok[sym]) ? leaf_at[sym] : 0;
        n = first;
        d = 0;
        while (n != 0 && n < NODES && d < NODES)
        begin
            d++;
            n = parent_m[n];
        end
        drop = (d > CAP) ? d - CAP : 0;
        cw.bits = '0;
        n = first;
        for (int k = 0; k < d; k++)
        begin
            if (k >= drop && n[0] == 1'b0) cw.bits[k - drop] = 1'b1;
            n = (n < NODES) ? parent_m[n] : 0;
        end
        cw.length = LEN_W'(d - drop);
        cw.fin = fin;
        return cw;
    endfunction

    // Queue the codes one accepted item produces and update the tree.
    function automatic void predict_codes(logic act, logic [7:0] sym);
        code_word_t lit;
        if (act == ACT_END)
        begin
            pending_codes.push_back(path_word(END_SYM, 1'b1));
            tree_clear();
        end
        else if (leaf_ok[sym])
        begin
            pending_codes.push_back(path_word(sym, 1'b1));
            bump_path(sym);
        end
        else
        begin
            pending_codes.push_back(path_word(ESC_SYM, 1'b0));
            lit.bits = CODE_W'(sym);
            lit.length = LEN_W'(LITERAL_W);
            lit.fin = 1'b1;
            pending_codes.push_back(lit);
            if (free_node + 2 <= NODES) split_lightest(sym);
            bump_path(sym);
        end
    endfunction

    // ---------------- checker ----------------
    always @(posedge clk)
    begin
        code_word_t want;
        if (rst_n && result_valid)
        begin
            if (pending_codes.size() == 0)
            begin
                $error("unexpected result code_bits=%h code_length=%0d", code_bits, code_length);
                errors++;
            end
            else
            begin
                want = pending_codes.pop_front();
                if (code_length !== want.length)
                begin
                    $error("code_length expected %0d actual %0d", want.length, code_length);
                    errors++;
                end
                if (code_bits !== want.bits)
                begin
                    $error("code_bits expected %h actual %h", want.bits, code_bits);
                    errors++;
                end
                if (last !== want.fin)
                begin
                    $error("last expected %b actual %b", want.fin, last);
                    errors++;
                end
            end
        end
    end

    // ---------------- drivers ----------------
    task automatic send_item(logic act, logic [7:0] sym);
        start <= 1'b1;
        action <= act;
        symbol <= sym;
        do @(posedge clk); while (busy);
        predict_codes(act, sym);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_codes.size() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(logic [LIMIT_W-1:0] value);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        limit_m = value;
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        send_item(ACT_END, 8'h00);
        send_item(ACT_CODE, 8'h00);
        send_item(ACT_CODE, 8'hFF);
        send_item(ACT_CODE, 8'h00);
        send_item(ACT_CODE, 8'hFF);
        send_item(ACT_CODE, 8'hFF);
        send_item(ACT_CODE, 8'hA5);
        send_item(ACT_CODE, 8'h5A);
        send_item(ACT_END, 8'hFF);
        send_item(ACT_CODE, 8'hFF);
        // Smallest limit forces a rebuild on almost every update.
        set_limit(16'd4);
        for (int i = 0; i < 10; i++) send_item(ACT_CODE, 8'(i % 3));
        send_item(ACT_END, 8'h00);
    endtask

    // Mostly a small alphabet so rebuilds stay cheap; end of stream now and then.
    task automatic test_random(int count, int alphabet, int pct);
        idle_pct = pct;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 3)
                send_item(ACT_END, 8'($urandom));
            else if ($urandom_range(99) < 10)
                send_item(ACT_CODE, 8'($urandom));
            else
                send_item(ACT_CODE, 8'($urandom_range(alphabet - 1)));
        end
    endtask

    // Long stream with all byte values and no rebuild.
    task automatic test_full_alphabet(int count, int pct);
        idle_pct = pct;
        for (int i = 0; i < count; i++) send_item(ACT_CODE, 8'($urandom));
        send_item(ACT_END, 8'h00);
    endtask

    initial
    begin
        tree_clear();
        limit_m = LIMIT_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        set_limit(16'd16);
        test_random(300, 8, 8);
        set_limit(16'd300);
        test_random(300, 16, 64);
        set_limit(16'd32768);
        test_full_alphabet(400, 0);
        set_limit(16'd4);
        test_random(200, 6, 0);
        set_limit(16'd1000);
        test_random(200, 24, 0);
        wait_idle();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
src/ahe_pkg.sv
src/ahe_ram.sv
src/adaptive_huffman_encoder.sv
tb/adaptive_huffman_encoder_test.sv
